// ===== rtl/wildcard_byte_pattern_scan_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern scanner
// Concurrent checks clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define WBPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WBPS_ASSERT_IMPL(label, ante, cons, msg)
`define WBPS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/wbps_pkg.sv =====
// ---------------------------------------------------------------------------
// wbps_pkg
// Shared constants, register codes and types of the pattern scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 16;
	localparam int ADDRESS_BITS_DEF      = 48;

	// Signature bytes held in the two pattern registers.
	localparam int SIG_BYTES = 16;
	localparam int SIG_W     = SIG_BYTES * 8;

	localparam logic [7:0] WILDCARD = 8'hFF;

	localparam int PAT_REG_W = 64;
	localparam int LEN_REG_W = 5;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 64;

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_BASE_ADDR    = 2'd3;

	localparam logic [LEN_REG_W-1:0] LEN_RESET = 5'd1;

	// Pending result between the scan stage and the output register.
	typedef struct packed {
		logic valid;
		logic found;
	} wbps_res_t;

	// Scan stage status seen by the top level.
	typedef struct packed {
		logic pending;
		logic reported;
	} wbps_status_t;

endpackage

`default_nettype wire

// ===== rtl/wildcard_byte_pattern_scan.sv =====
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Streaming scan of a byte region for a wildcard signature of up to 16 bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one byte per item in s_tdata[7:0], s_tlast marks the
//   last byte of a region. The next byte after s_tlast starts a new region at
//   offset zero. Output channel m_*: at most one result item per byte;
//   found in m_tuser, match address in m_tdata.
//   Signature bytes equal to 0xFF match any byte. The first full match gives
//   base_address plus the match start offset; later bytes of that region give
//   no item. A region that ends unmatched gives found = 0, address 0, at its
//   last byte.
//   A result item is registered first in the scan stage (window compare) and
//   then in the output register (address add) before it shows on m_tvalid.
//   Throughput: one byte per cycle while s_tready is high, set by the
//   combinational window compare and position subtract.
//   Stall: when m_tready is low the output register holds its item and one
//   more result waits in the scan stage; bytes that give no result keep
//   flowing, and s_tready drops only while both result slots are full.
//   Reset: arst_n clears the window, the region position, the match flag,
//   both result slots and the registers (pattern length back to one).
//   Configure through wr_en / wr_index / wr_data only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scan #(
	parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int ADDRESS_BITS      = wbps_pkg::ADDRESS_BITS_DEF,
	localparam int OUT_W            = ((ADDRESS_BITS + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration write port
	input  wire logic                           wr_en,
	input  wire logic [wbps_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [wbps_pkg::CFG_W-1:0]     wr_data,
	// Input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,  // [7:0] data_byte
	input  wire logic                           s_tlast,  // region_end
	// Result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic                                m_tuser,  // found
	output logic [OUT_W-1:0]                    m_tdata   // match_address, zero fill
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

	logic [wbps_pkg::PAT_REG_W-1:0] pat_low_q;
	logic [wbps_pkg::PAT_REG_W-1:0] pat_high_q;
	logic [wbps_pkg::LEN_REG_W-1:0] len_q;
	logic [ADDRESS_BITS-1:0]        base_q;
	logic [LEN_W-1:0]               len_eff;

	wbps_pkg::wbps_res_t            res_s1;
	wbps_pkg::wbps_status_t         status;
	logic [ADDRESS_BITS-1:0]        off_s1;
	logic                           take;
	logic                           found;
	logic [ADDRESS_BITS-1:0]        match_address;

	// Register file; base address keeps only ADDRESS_BITS bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_q      <= wbps_pkg::LEN_RESET;
			base_q     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				wbps_pkg::REG_PATTERN_LOW:  pat_low_q  <= wr_data[wbps_pkg::PAT_REG_W-1:0];
				wbps_pkg::REG_PATTERN_HIGH: pat_high_q <= wr_data[wbps_pkg::PAT_REG_W-1:0];
				wbps_pkg::REG_PATTERN_LEN:  len_q      <= wr_data[wbps_pkg::LEN_REG_W-1:0];
				wbps_pkg::REG_BASE_ADDR:    base_q     <= wr_data[ADDRESS_BITS-1:0];
			endcase
		end
	end

	// Clamp the length: zero acts as one, anything above the window as full.
	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(len_q) > MAX_PATTERN_BYTES) begin
			len_eff = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_eff = LEN_W'(len_q);
		end
	end

	wbps_scan #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
		.ADDRESS_BITS(ADDRESS_BITS),
		.LEN_W(LEN_W)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.data_byte(s_tdata),
		.region_end(s_tlast),
		.in_ready(s_tready),
		.pattern({pat_high_q, pat_low_q}),
		.len_eff(len_eff),
		.take(take),
		.res_s1(res_s1),
		.off_s1(off_s1),
		.status(status)
	);

	wbps_result #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_result (
		.clk(clk),
		.arst_n(arst_n),
		.res_s1(res_s1),
		.off_s1(off_s1),
		.base(base_q),
		.out_ready(m_tready),
		.take(take),
		.out_valid(m_tvalid),
		.found(found),
		.match_address(match_address)
	);

	// Flag on tuser, address on tdata with zero fill to whole bytes.
	assign m_tuser = found;
	assign m_tdata = OUT_W'(match_address);

`include "wildcard_byte_pattern_scan_defines.svh"

	`WBPS_ASSERT_IMPL(a_miss_zero_addr, m_tvalid && !m_tuser, m_tdata == '0, "not-found result with nonzero address")
	`WBPS_ASSERT_IMPL(a_full_blocks_input, status.pending && m_tvalid && !m_tready, !s_tready, "input accepted with both result slots full")
	`WBPS_ASSERT_IMPL(a_free_slot_ready, !status.pending, s_tready, "input stalled with free result slot")
	`WBPS_ASSERT_NEXT(a_region_end_clears, s_tvalid && s_tready && s_tlast, !status.reported, "match flag survives region end")

endmodule

`default_nettype wire

// ===== rtl/wbps_match.sv =====
// ---------------------------------------------------------------------------
// wbps_match
// Parallel compare of the byte window against the aligned signature.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_match #(
	parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  wire logic [MAX_PATTERN_BYTES*8-1:0] window,
	input  wire logic [wbps_pkg::SIG_W-1:0]     pattern,
	input  wire logic [LEN_W-1:0]               len_eff,
	output logic                                hit
);

	localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	// Signature byte j lines up with window entry len-1-j (entry 0 newest).
	always_comb begin
		logic [7:0]       sig;
		logic [IDX_W-1:0] pos;
		hit = 1'b1;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			if (j < wbps_pkg::SIG_BYTES) begin
				sig = pattern[8*(j % wbps_pkg::SIG_BYTES) +: 8];
			end else begin
				sig = wbps_pkg::WILDCARD;
			end
			pos = IDX_W'(int'(len_eff) - 1 - j);
			if (j < int'(len_eff)) begin
				if (sig != wbps_pkg::WILDCARD && sig != window[8*pos +: 8]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wbps_scan.sv =====
// ---------------------------------------------------------------------------
// wbps_scan
// Byte window, region position and match decision; holds one pending result.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_scan #(
	parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int ADDRESS_BITS      = wbps_pkg::ADDRESS_BITS_DEF,
	parameter int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        region_end,
	output logic                             in_ready,
	input  wire logic [wbps_pkg::SIG_W-1:0]  pattern,
	input  wire logic [LEN_W-1:0]            len_eff,
	input  wire logic                        take,
	output wbps_pkg::wbps_res_t              res_s1,
	output logic [ADDRESS_BITS-1:0]          off_s1,
	output wbps_pkg::wbps_status_t           status
);

	localparam int WIN_W = MAX_PATTERN_BYTES * 8;

	logic [WIN_W-1:0]        win_q;
	logic [WIN_W-1:0]        win_n;
	logic [ADDRESS_BITS-1:0] pos_q;
	logic                    reported_q;
	logic                    inc;
	logic [LEN_W-1:0]        sub;
	logic [ADDRESS_BITS:0]   diff;
	logic                    hit_pat;
	logic                    hit;
	logic                    accept;
	logic                    give;

	// Shift the new byte in as entry 0.
	assign win_n = WIN_W'({win_q, data_byte});

	wbps_match #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
		.LEN_W(LEN_W)
	) u_match (
		.window(win_n),
		.pattern(pattern),
		.len_eff(len_eff),
		.hit(hit_pat)
	);

	// count - len in one subtract; borrow means the region is still too short.
	assign inc  = ~&pos_q;
	assign sub  = len_eff - LEN_W'(inc);
	assign diff = {1'b0, pos_q} - (ADDRESS_BITS + 1)'(sub);
	assign hit  = hit_pat && !diff[ADDRESS_BITS];

	assign accept   = in_valid && in_ready;
	assign give     = !reported_q && (hit || region_end);
	assign in_ready = !res_s1.valid || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (region_end) begin
				win_q      <= '0;
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				win_q      <= win_n;
				pos_q      <= pos_q + ADDRESS_BITS'(inc);
				reported_q <= reported_q || hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else if (accept && give) begin
			res_s1.valid <= 1'b1;
			res_s1.found <= hit;
		end else if (take) begin
			res_s1.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && give) begin
			off_s1 <= diff[ADDRESS_BITS-1:0];
		end
	end

	assign status.pending  = res_s1.valid;
	assign status.reported = reported_q;

endmodule

`default_nettype wire

// ===== rtl/wbps_result.sv =====
// ---------------------------------------------------------------------------
// wbps_result
// Output register: forms the match address and holds the result item.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_result #(
	parameter int ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire wbps_pkg::wbps_res_t     res_s1,
	input  wire logic [ADDRESS_BITS-1:0] off_s1,
	input  wire logic [ADDRESS_BITS-1:0] base,
	input  wire logic                    out_ready,
	output logic                         take,
	output logic                         out_valid,
	output logic                         found,
	output logic [ADDRESS_BITS-1:0]      match_address
);

	logic valid_q;

	assign take      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= res_s1.valid;
		end
	end

	// Address wraps modulo 2^ADDRESS_BITS; a miss reports zero.
	always_ff @(posedge clk) begin
		if (take && res_s1.valid) begin
			found         <= res_s1.found;
			match_address <= res_s1.found ? (base + off_s1) : '0;
		end
	end

endmodule

`default_nettype wire

// ===== test/wildcard_byte_pattern_scan_test.sv =====
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan_test
// Self-checking bench for the wildcard signature scanner. A table of directed
// bytes and register writes runs first, then random phases of byte regions.
// Each accepted byte is run through an in-bench scan predictor, and every
// result item is compared field by field with the oldest pending prediction.
// ---------------------------------------------------------------------------
module wildcard_byte_pattern_scan_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wbps_pkg::*;

	localparam int ADDR_W       = ADDRESS_BITS_DEF;
	localparam int WIN_LEN      = MAX_PATTERN_BYTES_DEF;
	localparam int RES_W        = ((ADDR_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 2000;
	// Two-stage pipeline; spare drain time for bytes that give no item.
	localparam int DRAIN_CYCLES = 8;
	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} scan_res_t;

	// How a directed byte row is checked.
	typedef enum logic [1:0] {
		CHK_MODEL,  // whatever the predictor gives
		CHK_NONE,   // no result item
		CHK_FOUND,  // found, at the typed address
		CHK_MISS    // not found
	} chk_t;

	typedef struct {
		bit                   is_write;
		logic [REG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;   // register value, or typed address for CHK_FOUND
		logic [7:0]           b;
		bit                   last;
		chk_t                 chk;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [7:0] data_byte
	logic                 s_tlast;   // region_end
	logic                 m_tvalid;
	logic                 m_tready;
	logic                 m_tuser;   // found
	logic [RES_W-1:0]     m_tdata;   // [47:0] match_address

	// Predictor copy of the registers and the scan state.
	logic [PAT_REG_W-1:0] sig_low;
	logic [PAT_REG_W-1:0] sig_high;
	logic [LEN_REG_W-1:0] sig_len;
	logic [ADDR_W-1:0]    base_addr;
	logic [7:0]           win [WIN_LEN];
	logic [ADDR_W-1:0]    seen_bytes;
	bit                   region_hit;

	scan_res_t expected_results [$];
	step_row_t rows [$];
	logic [7:0] bytes_q [$];
	int        mismatches;
	int        scanned_items;
	bit        tx_burst;

	wildcard_byte_pattern_scan dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Append helpers for the bench queues.
	function automatic void expect_item(input scan_res_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void add_row(input step_row_t r);
		rows.insert(rows.size(), r);
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		bytes_q.insert(bytes_q.size(), b);
	endfunction

	// Effective signature length: zero acts as one, anything above the window
	// clamps to the window size.
	function automatic int used_len();
		int n;
		n = sig_len;
		if (n == 0) begin
			n = 1;
		end
		if (n > WIN_LEN) begin
			n = WIN_LEN;
		end
		return n;
	endfunction

	function automatic logic [7:0] sig_byte(input int k);
		logic [SIG_W-1:0] sig;
		sig = {sig_high, sig_low};
		return sig[8*k +: 8];
	endfunction

	function automatic void clear_region();
		foreach (win[i]) begin
			win[i] = 8'h00;
		end
		seen_bytes = '0;
		region_hit = 1'b0;
	endfunction

	// Advance the scan by one byte; return 1 when the byte gives a result item.
	function automatic bit scan_byte(input logic [7:0] b, input bit last,
			output scan_res_t res);
		int n;
		bit hit;
		res = '0;
		for (int i = WIN_LEN - 1; i > 0; i--) begin
			win[i] = win[i-1];
		end
		win[0] = b;
		if (seen_bytes != ADDR_MAX) begin
			seen_bytes++;
		end
		// Bytes after a match are dropped, region end included.
		if (region_hit) begin
			if (last) begin
				clear_region();
			end
			return 1'b0;
		end
		n = used_len();
		hit = (seen_bytes >= n);
		// Signature byte j lines up with the j-th oldest of the last n bytes of the window.
		for (int j = 0; j < n; j++) begin
			if (sig_byte(j) != WILDCARD && sig_byte(j) != win[n-1-j]) begin
				hit = 1'b0;
			end
		end
		if (hit) begin
			res.found = 1'b1;
			res.addr  = base_addr + seen_bytes - ADDR_W'(n);
			if (last) begin
				clear_region();
			end else begin
				region_hit = 1'b1;
			end
			return 1'b1;
		end
		if (last) begin
			clear_region();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic step_row_t wr_row(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		step_row_t r;
		r = '{is_write: 1'b1, idx: idx, val: val, b: 8'h00, last: 1'b0, chk: CHK_NONE};
		return r;
	endfunction

	function automatic step_row_t byte_row(input logic [7:0] b, input bit last,
			input chk_t chk, input logic [CFG_W-1:0] addr);
		step_row_t r;
		r = '{is_write: 1'b0, idx: REG_PATTERN_LOW, val: addr, b: b, last: last, chk: chk};
		return r;
	endfunction

	function automatic logic [7:0] noise_byte(input bit narrow);
		return narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
	endfunction

	// Mix of wildcards, a small alphabet (so noise can hit by chance) and full range.
	function automatic logic [PAT_REG_W-1:0] random_sig();
		logic [PAT_REG_W-1:0] v;
		int r;
		for (int k = 0; k < PAT_REG_W / 8; k++) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				v[8*k +: 8] = WILDCARD;
			end else if (r < 7) begin
				v[8*k +: 8] = noise_byte(1'b1);
			end else begin
				v[8*k +: 8] = noise_byte(1'b0);
			end
		end
		return v;
	endfunction

	// Write one register at the next edge and track it; the caller drops wr_en.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			REG_PATTERN_LOW:  sig_low = val;
			REG_PATTERN_HIGH: sig_high = val;
			REG_PATTERN_LEN:  sig_len = val[LEN_REG_W-1:0];
			REG_BASE_ADDR:    base_addr = val[ADDR_W-1:0];
			default: ;
		endcase
	endtask

	// Hold off the sender until every pending item is back, then let the
	// pipeline run dry in case the last bytes gave nothing.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offer one byte after a random gap, wait for the handshake, then predict.
	task automatic feed_byte(input logic [7:0] b, input bit last, input chk_t chk,
			input logic [ADDR_W-1:0] typed_addr);
		int gap;
		bit gives;
		scan_res_t res;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		scanned_items++;
		gives = scan_byte(b, last, res);
		case (chk)
			CHK_MODEL: begin
				if (gives) begin
					expect_item(res);
				end
			end
			CHK_FOUND: expect_item(scan_res_t'{found: 1'b1, addr: typed_addr});
			CHK_MISS:  expect_item(scan_res_t'{found: 1'b0, addr: '0});
			default: ;
		endcase
	endtask

	// One random phase: reprogram some registers while idle, then stream a few
	// regions. Most regions carry the signature with random wildcard fill; the
	// rest are noise or cut off partway through the signature.
	task automatic random_phase(input bit first);
		logic [3:0] mask;
		logic [7:0] sb;
		logic [LEN_REG_W-1:0] len;
		logic [ADDR_W-1:0] base;
		int regions;
		int n;
		int keep;
		int r;
		bit narrow;
		bit open_end;
		wait_idle();
		mask = first ? 4'hF : 4'($urandom_range(1, 15));
		if (mask[REG_PATTERN_LOW]) begin
			write_reg(REG_PATTERN_LOW, random_sig());
		end
		if (mask[REG_PATTERN_HIGH]) begin
			write_reg(REG_PATTERN_HIGH, random_sig());
		end
		if (mask[REG_PATTERN_LEN]) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				case ($urandom_range(0, 3))
					0: len = 5'd0;
					1: len = 5'd1;
					2: len = 5'd16;
					default: len = 5'd31;
				endcase
			end else if (r < 7) begin
				len = 5'($urandom_range(1, 6));
			end else begin
				len = 5'($urandom_range(0, 31));
			end
			write_reg(REG_PATTERN_LEN, CFG_W'(len));
		end
		if (mask[REG_BASE_ADDR]) begin
			r = $urandom_range(0, 5);
			if (r == 0) begin
				base = '0;
			end else if (r == 1) begin
				base = ADDR_MAX - ADDR_W'($urandom_range(0, 40));
			end else begin
				base = ADDR_W'({$urandom, $urandom});
			end
			write_reg(REG_BASE_ADDR, CFG_W'(base));
		end
		wr_en <= 1'b0;

		tx_burst = ($urandom_range(0, 4) == 0);
		narrow   = $urandom_range(0, 1);
		regions  = $urandom_range(1, 6);
		for (int g = 0; g < regions; g++) begin
			bytes_q.delete();
			n = used_len();
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(0, 8)) add_byte(noise_byte(narrow));
				keep = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : n;
				for (int k = 0; k < keep; k++) begin
					sb = sig_byte(k);
					add_byte(sb == WILDCARD ? noise_byte(narrow) : sb);
				end
				repeat ($urandom_range(0, 4)) add_byte(noise_byte(narrow));
			end else begin
				repeat ($urandom_range(1, 20)) add_byte(noise_byte(narrow));
			end
			if (bytes_q.size() == 0) begin
				add_byte(noise_byte(narrow));
			end
			// Now and then leave the last region open across the next register write.
			open_end = (g == regions - 1) && ($urandom_range(0, 4) == 0);
			foreach (bytes_q[i]) begin
				feed_byte(bytes_q[i], (i == bytes_q.size() - 1) && !open_end, CHK_MODEL, '0);
			end
		end
	endtask

	// Result sink: random stall before each item, with stretches of none.
	initial begin : result_sink
		scan_res_t want;
		int stall;
		int burst_left;
		burst_left = 0;
		forever begin
			if (burst_left > 0) begin
				stall = 0;
				burst_left--;
			end else begin
				stall = $urandom_range(0, 11);
				if ($urandom_range(0, 29) == 0) begin
					burst_left = $urandom_range(20, 60);
				end
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual found=%0b addr=%h",
					$time, m_tuser, m_tdata[ADDR_W-1:0]);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.found) begin
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, want.found, m_tuser);
					mismatches++;
				end
				if (m_tdata[ADDR_W-1:0] !== want.addr) begin
					$display("%0t: match_address mismatch, expected %h, actual %h",
						$time, want.addr, m_tdata[ADDR_W-1:0]);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		bit wr_busy;
		int phase;
		arst_n   <= 1'b0;
		wr_en    <= 1'b0;
		wr_index <= REG_PATTERN_LOW;
		wr_data  <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tlast  <= 1'b0;
		tx_burst = 1'b0;
		mismatches = 0;
		scanned_items = 0;
		sig_low   = '0;
		sig_high  = '0;
		sig_len   = LEN_RESET;
		base_addr = '0;
		clear_region();

		// Out of reset: length one, signature byte zero is 0x00, base zero.
		add_row(byte_row(8'h00, 1'b0, CHK_FOUND, '0));
		add_row(byte_row(8'h55, 1'b1, CHK_NONE, '0));   // region end after a match
		add_row(byte_row(8'h01, 1'b1, CHK_MISS, '0));
		// Top address, zero length acting as one, wildcard byte.
		add_row(wr_row(REG_BASE_ADDR, CFG_W'(ADDR_MAX)));
		add_row(wr_row(REG_PATTERN_LEN, '0));
		add_row(wr_row(REG_PATTERN_LOW, 64'h0000_0000_0000_00FF));
		add_row(byte_row(8'hA5, 1'b0, CHK_FOUND, CFG_W'(ADDR_MAX)));
		add_row(byte_row(8'h5A, 1'b1, CHK_NONE, '0));
		// Two-byte signature; a hit at offset one wraps the address.
		add_row(wr_row(REG_PATTERN_LEN, 64'd2));
		add_row(wr_row(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_BBAA));
		add_row(byte_row(8'h11, 1'b0, CHK_NONE, '0));
		add_row(byte_row(8'hAA, 1'b0, CHK_NONE, '0));
		add_row(byte_row(8'hBB, 1'b0, CHK_MODEL, '0));
		add_row(byte_row(8'hAA, 1'b1, CHK_NONE, '0));
		add_row(byte_row(8'hAA, 1'b1, CHK_MISS, '0));   // region shorter than signature
		// Oversized length clamps to sixteen; match lands on the region's last byte.
		add_row(wr_row(REG_PATTERN_LEN, 64'd31));
		add_row(wr_row(REG_PATTERN_LOW, 64'h0706_0504_0302_0100));
		add_row(wr_row(REG_PATTERN_HIGH, 64'hFF0E_0D0C_0B0A_09FF));
		add_row(wr_row(REG_BASE_ADDR, '0));
		for (int k = 0; k < WIN_LEN; k++) begin
			if (k == WIN_LEN - 1) begin
				add_row(byte_row(8'hF0, 1'b1, CHK_FOUND, '0));
			end else begin
				add_row(byte_row(k == 8 ? 8'hC3 : 8'(k), 1'b0, CHK_NONE, '0));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		wr_busy = 1'b0;
		foreach (rows[i]) begin
			if (rows[i].is_write) begin
				if (!wr_busy) begin
					wait_idle();
				end
				write_reg(rows[i].idx, rows[i].val);
				wr_busy = 1'b1;
			end else begin
				if (wr_busy) begin
					wr_en <= 1'b0;
				end
				wr_busy = 1'b0;
				feed_byte(rows[i].b, rows[i].last, rows[i].chk, rows[i].val[ADDR_W-1:0]);
			end
		end

		scanned_items = 0;
		phase = 0;
		while (scanned_items < RANDOM_ITEMS) begin
			random_phase(phase == 0);
			phase++;
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
